FILE: src/tpe_pkg.sv
// ============================================================================
// tpe_pkg: shared types and constants for tile passability and erosion
// Holds the line buffer geometry, the configuration register codes and the
// queue entry that travels from the front end to the back end.
// ============================================================================
package tpe_pkg;

    // Line buffer geometry
    localparam int MAX_WIDTH    = 2048;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int LINE_W       = 2;
    localparam int HEIGHT_LIMIT = 2048;

    // Field and register widths
    localparam int CFG_W       = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int COORD_W     = 11;
    localparam int WINDOW_W    = 9;

    // Front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1
    } cfg_reg_t;

    // One classified tile waiting for the window update
    typedef struct packed {
        logic               walkable;
        logic               blocks_sight;
        logic               sight_up;
        logic               sight_mid;
        logic               obscured_valid;
        logic [COORD_W-1:0] obscured_col;
        logic [COORD_W-1:0] obscured_row;
        logic               last_tile;
    } entry_t;

endpackage

FILE: src/tpe_in_if.sv
// ============================================================================
// tpe_in_if: tile input channel
// Valid/ready channel that carries the attribute flags of one map tile.
// ============================================================================
interface tpe_in_if;
    logic valid;
    logic ready;
    logic tile_walkable;
    logic tile_blocks_sight;
    logic wall_present;
    logic wall_walkable;
    logic wall_blocks_sight;
    logic doodad_present;
    logic doodad_walkable;

    modport source (
        output valid, tile_walkable, tile_blocks_sight, wall_present,
               wall_walkable, wall_blocks_sight, doodad_present, doodad_walkable,
        input  ready
    );

    modport sink (
        input  valid, tile_walkable, tile_blocks_sight, wall_present,
               wall_walkable, wall_blocks_sight, doodad_present, doodad_walkable,
        output ready
    );
endinterface

FILE: src/tpe_out_if.sv
// ============================================================================
// tpe_out_if: tile result channel
// Valid/ready channel that carries the result of one map tile.
// ============================================================================
interface tpe_out_if;
    logic                        valid;
    logic                        ready;
    logic                        walkable;
    logic                        blocks_sight;
    logic                        obscured_valid;
    logic                        obscured;
    logic [tpe_pkg::COORD_W-1:0] obscured_col;
    logic [tpe_pkg::COORD_W-1:0] obscured_row;
    logic                        last_tile;

    modport source (
        output valid, walkable, blocks_sight, obscured_valid, obscured,
               obscured_col, obscured_row, last_tile,
        input  ready
    );

    modport sink (
        input  valid, walkable, blocks_sight, obscured_valid, obscured,
               obscured_col, obscured_row, last_tile,
        output ready
    );
endinterface

FILE: src/tpe_ram.sv
// ============================================================================
// tpe_ram: generic simple dual port RAM
// One write port and one read port with registered read data.
// ============================================================================
module tpe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write and registered read; read data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/tpe_front.sv
// ============================================================================
// tpe_front: tile classification front end
// Holds the map size registers and the raster counters, classifies each tile
// and reads and updates the two sight line buffers before queueing the tile.
// ============================================================================
module tpe_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpe_pkg::CFG_W-1:0]       cfg_data,
    output logic                            restart,
    tpe_in_if.sink                          in_ch,
    output logic                            push,
    output tpe_pkg::entry_t                 push_entry,
    input  logic                            queue_full
);

    logic [tpe_pkg::CFG_W-1:0]   width_reg;
    logic [tpe_pkg::CFG_W-1:0]   height_reg;
    logic [tpe_pkg::CFG_W-1:0]   width_eff;
    logic [tpe_pkg::CFG_W-1:0]   height_eff;
    logic [tpe_pkg::COORD_W-1:0] col_reg;
    logic [tpe_pkg::COORD_W-1:0] row_reg;
    logic [tpe_pkg::COORD_W-1:0] col_next;
    logic [tpe_pkg::COORD_W-1:0] row_next;
    logic [tpe_pkg::CFG_W-1:0]   col_inc;
    logic [tpe_pkg::CFG_W-1:0]   row_inc;
    logic                        accept;
    logic                        width_hit;
    logic                        height_hit;

    // Stage register holding the tile whose line buffer read is in flight
    logic                        f_valid_reg;
    logic                        f_walk_reg;
    logic                        f_sight_reg;
    logic                        f_ovalid_reg;
    logic [tpe_pkg::COORD_W-1:0] f_col_reg;
    logic [tpe_pkg::COORD_W-1:0] f_row_reg;
    logic                        f_last_reg;
    logic [tpe_pkg::ADDR_W-1:0]  f_addr_reg;

    logic                        tile_walk;
    logic                        tile_sight;
    logic                        tile_ovalid;
    logic [tpe_pkg::LINE_W-1:0]  line_rd;
    logic [tpe_pkg::LINE_W-1:0]  line_wr;

    // Register write decode; a write to a known register restarts the map.
    always_comb
    begin
        width_hit  = 1'b0;
        height_hit = 1'b0;
        case (cfg_index)
            tpe_pkg::REG_MAP_WIDTH:  width_hit  = cfg_wr_en;
            tpe_pkg::REG_MAP_HEIGHT: height_hit = cfg_wr_en;
            default:                 ;
        endcase
    end

    assign restart = width_hit | height_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tpe_pkg::CFG_W'(1);
            height_reg <= tpe_pkg::CFG_W'(1);
        end
        else
        begin
            if (width_hit)
            begin
                width_reg <= cfg_data;
            end
            if (height_hit)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // Effective map size: zero acts as one, oversize is clamped.
    always_comb
    begin
        if (width_reg == '0)
            width_eff = tpe_pkg::CFG_W'(1);
        else if (width_reg > tpe_pkg::CFG_W'(tpe_pkg::MAX_WIDTH))
            width_eff = tpe_pkg::CFG_W'(tpe_pkg::MAX_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg == '0)
            height_eff = tpe_pkg::CFG_W'(1);
        else if (height_reg > tpe_pkg::CFG_W'(tpe_pkg::HEIGHT_LIMIT))
            height_eff = tpe_pkg::CFG_W'(tpe_pkg::HEIGHT_LIMIT);
        else
            height_eff = height_reg;
    end

    // Handshake: the stage takes a tile when empty or when its tile moves on.
    assign push         = f_valid_reg & ~queue_full;
    assign in_ch.ready  = ~f_valid_reg | ~queue_full;
    assign accept       = in_ch.valid & in_ch.ready;

    // Tile classification
    assign tile_walk  = in_ch.tile_walkable
                      & ~(in_ch.wall_present & ~in_ch.wall_walkable)
                      & ~(in_ch.doodad_present & ~in_ch.doodad_walkable);
    assign tile_sight = in_ch.tile_blocks_sight
                      | (in_ch.wall_present & in_ch.wall_blocks_sight);
    assign tile_ovalid = (col_reg >= tpe_pkg::COORD_W'(2))
                       & (row_reg >= tpe_pkg::COORD_W'(2));

    // Raster counter advance
    always_comb
    begin
        col_inc = {1'b0, col_reg} + tpe_pkg::CFG_W'(1);
        row_inc = {1'b0, row_reg} + tpe_pkg::CFG_W'(1);
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : row_inc[tpe_pkg::COORD_W-1:0];
        end
        else
        begin
            col_next = col_inc[tpe_pkg::COORD_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_walk_reg   <= tile_walk;
            f_sight_reg  <= tile_sight;
            f_ovalid_reg <= tile_ovalid;
            f_col_reg    <= tile_ovalid ? (col_reg - tpe_pkg::COORD_W'(1)) : '0;
            f_row_reg    <= tile_ovalid ? (row_reg - tpe_pkg::COORD_W'(1)) : '0;
            f_last_reg   <= ({1'b0, col_reg} == width_eff - tpe_pkg::CFG_W'(1))
                          & ({1'b0, row_reg} == height_eff - tpe_pkg::CFG_W'(1));
            f_addr_reg   <= col_reg[tpe_pkg::ADDR_W-1:0];
        end
    end

    // Line buffers: bit 1 is the row two above, bit 0 the row one above.
    // On transfer to the queue the middle bit moves up and the new sight
    // bit becomes the middle.
    assign line_wr = {line_rd[0], f_sight_reg};

    tpe_ram #(
        .WIDTH (tpe_pkg::LINE_W),
        .DEPTH (tpe_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (f_addr_reg),
        .wr_data (line_wr),
        .rd_en   (accept),
        .rd_addr (col_reg[tpe_pkg::ADDR_W-1:0]),
        .rd_data (line_rd)
    );

    // Queue entry
    always_comb
    begin
        push_entry.walkable       = f_walk_reg;
        push_entry.blocks_sight   = f_sight_reg;
        push_entry.sight_up       = line_rd[1];
        push_entry.sight_mid      = line_rd[0];
        push_entry.obscured_valid = f_ovalid_reg;
        push_entry.obscured_col   = f_col_reg;
        push_entry.obscured_row   = f_row_reg;
        push_entry.last_tile      = f_last_reg;
    end

endmodule

FILE: src/tpe_queue.sv
// ============================================================================
// tpe_queue: short queue between front and back ends
// Register based first-in first-out buffer of classified tiles.
// ============================================================================
module tpe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tpe_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output tpe_pkg::entry_t pop_entry,
    output logic            empty
);

    tpe_pkg::entry_t            entries [tpe_pkg::QUEUE_DEPTH];
    logic [tpe_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [tpe_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [tpe_pkg::QCNT_W-1:0] count_reg;

    assign full      = (count_reg == tpe_pkg::QCNT_W'(tpe_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = entries[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == tpe_pkg::QPTR_W'(tpe_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + tpe_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == tpe_pkg::QPTR_W'(tpe_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + tpe_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + tpe_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - tpe_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

FILE: src/tpe_back.sv
// ============================================================================
// tpe_back: erosion back end
// Shifts each queued tile's sight column into the 3x3 window, forms the
// obscured verdict and holds the result in the output register.
// ============================================================================
module tpe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart,
    input  logic            queue_empty,
    input  tpe_pkg::entry_t pop_entry,
    output logic            pop,
    tpe_out_if.source       out_ch
);

    logic [tpe_pkg::WINDOW_W-1:0] window_reg;
    logic [tpe_pkg::WINDOW_W-1:0] window_next;
    logic                         out_valid_reg;
    tpe_pkg::entry_t              out_entry_reg;
    logic                         out_obscured_reg;

    // Take the next tile when the output register is free or being emptied.
    assign pop = ~queue_empty & (~out_valid_reg | out_ch.ready);

    // Newest column in the low bits: row two above, row one above, this row.
    assign window_next = {window_reg[tpe_pkg::WINDOW_W-4:0],
                          pop_entry.sight_up, pop_entry.sight_mid,
                          pop_entry.blocks_sight};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (restart)
        begin
            window_reg <= '0;
        end
        else if (pop)
        begin
            window_reg <= window_next;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_entry_reg    <= pop_entry;
            out_obscured_reg <= pop_entry.obscured_valid & (&window_next);
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.walkable       = out_entry_reg.walkable;
    assign out_ch.blocks_sight   = out_entry_reg.blocks_sight;
    assign out_ch.obscured_valid = out_entry_reg.obscured_valid;
    assign out_ch.obscured       = out_obscured_reg;
    assign out_ch.obscured_col   = out_entry_reg.obscured_col;
    assign out_ch.obscured_row   = out_entry_reg.obscured_row;
    assign out_ch.last_tile      = out_entry_reg.last_tile;

endmodule

FILE: src/tile_passability_and_erosion.sv
// ============================================================================
// tile_passability_and_erosion: tile passability and sight erosion
// Classifies map tiles in raster order and runs a 3x3 erosion of sight bits.
// ============================================================================
// Tiles arrive on in_ch in raster order, one transfer per tile, and each
// tile gives exactly one result transfer on out_ch: its walkable and
// sight-blocking bits, plus the obscured verdict for the tile one row up
// and one column left when that tile is interior, and a flag on the final
// tile of the map. Map width and height are set through the write port
// (index 0 is width, 1 is height); the user must write them only while the
// block is idle, which the block does not enforce. Any such write restarts
// the map at column 0, row 0. A result passes the front stage, the queue
// and the output register. The block sustains one tile per cycle: the front
// stage reads and updates one line buffer RAM entry per tile, and the back
// end shifts one window column per tile. A two-entry queue and an output
// register let the input keep flowing while a result waits; when the
// receiver stalls, the input stalls only once the queue and the front stage
// are full. Reset sets width and height to 1, clears the counters, the
// window and all pending transfers. The line buffers are not cleared:
// entries read before they are written within a map never reach an output.
// ============================================================================
module tile_passability_and_erosion (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpe_pkg::CFG_W-1:0]       cfg_data,
    tpe_in_if.sink                          in_ch,
    tpe_out_if.source                       out_ch
);

    logic            restart;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;
    tpe_pkg::entry_t push_entry;
    tpe_pkg::entry_t pop_entry;

    // Front end: size registers, counters, classification, line buffers
    tpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .restart    (restart),
        .in_ch      (in_ch),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    // Queue between the two ends
    tpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty)
    );

    // Back end: window, verdict and output register
    tpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .queue_empty (queue_empty),
        .pop_entry   (pop_entry),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking testbench for tile_passability_and_erosion
// Streams map tiles into the block under several map sizes and compares
// every result transfer, field by field, against a built-in predictor of
// the tile classification and the 3x3 sight erosion. Both channels idle at
// random, and one long receiver hold-off backs the block up into its input.
// ============================================================================
module tb_top;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 800000;
    localparam int RANDOM_TILES = 1450;
    localparam int WIDE_TILES   = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int SETTLE       = 4;
    localparam int MAX_GAP      = 10;
    localparam int REPORT_LIMIT = 10;

    // Register indexes that the block does not decode
    localparam logic [tpe_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [tpe_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [tpe_pkg::CFG_W-1:0]       SIZE_TOP    = '1;

    // Attribute flags of one tile, in channel order
    typedef struct packed {
        logic tile_walkable;
        logic tile_blocks_sight;
        logic wall_present;
        logic wall_walkable;
        logic wall_blocks_sight;
        logic doodad_present;
        logic doodad_walkable;
    } tile_t;

    // Result of one tile
    typedef struct packed {
        logic                        walkable;
        logic                        blocks_sight;
        logic                        obscured_valid;
        logic                        obscured;
        logic [tpe_pkg::COORD_W-1:0] obscured_col;
        logic [tpe_pkg::COORD_W-1:0] obscured_row;
        logic                        last_tile;
    } verdict_t;

    typedef enum logic {STEP_TILE, STEP_WRITE} step_kind_t;
    typedef enum logic {WANT_PREDICTED, WANT_TYPED} want_src_t;

    typedef struct packed {
        step_kind_t                      kind;
        logic [tpe_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [tpe_pkg::CFG_W-1:0]       reg_value;
        tile_t                           tile;
        want_src_t                       want_src;
        logic                            want_walkable;
        logic                            want_sight;
        logic                            want_last;
    } step_t;

    // Directed steps. Tile flag order: tile walkable, tile sight, wall present,
    // wall walkable, wall sight, doodad present, doodad walkable. Typed rows
    // run on a one-tile map, so every result there is the final tile.
    localparam int NUM_STEPS = 28;
    localparam step_t STEPS [NUM_STEPS] = '{
        // Walkable and sight logic on the reset map size of 1x1
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0000000, WANT_TYPED, 1'b0, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1000000, WANT_TYPED, 1'b1, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1010000, WANT_TYPED, 1'b0, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1011000, WANT_TYPED, 1'b1, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1001000, WANT_TYPED, 1'b1, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1000010, WANT_TYPED, 1'b0, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1000011, WANT_TYPED, 1'b1, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1000001, WANT_TYPED, 1'b1, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0100000, WANT_TYPED, 1'b0, 1'b1, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0010100, WANT_TYPED, 1'b0, 1'b1, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0000100, WANT_TYPED, 1'b0, 1'b0, 1'b1},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1111111, WANT_TYPED, 1'b1, 1'b1, 1'b1},
        // A zero width and height behave as one
        '{STEP_WRITE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0000000, WANT_TYPED, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, tpe_pkg::REG_MAP_HEIGHT, 12'd0, 7'b0000000, WANT_TYPED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0110101, WANT_TYPED, 1'b0, 1'b1, 1'b1},
        // Fully blocking 3x3 map, with an ignored write in the middle of it
        '{STEP_WRITE, tpe_pkg::REG_MAP_WIDTH, 12'd3, 7'b0000000, WANT_TYPED, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, tpe_pkg::REG_MAP_HEIGHT, 12'd3, 7'b0000000, WANT_TYPED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0100000, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0100000, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0110100, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0100000, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, REG_SPARE_A, 12'hFFF, 7'b0000000, WANT_TYPED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0100000, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0011111, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0100000, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b0100000, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_TILE, tpe_pkg::REG_MAP_WIDTH, 12'd0, 7'b1100000, WANT_PREDICTED, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, REG_SPARE_B, 12'h555, 7'b0000000, WANT_TYPED, 1'b0, 1'b0, 1'b0}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [tpe_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tpe_pkg::CFG_W-1:0]       cfg_data;

    tpe_in_if  in_ch ();
    tpe_out_if out_ch ();

    tile_passability_and_erosion u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state: map size, the two sight rows above, the window and
    // the position of the next tile
    logic [tpe_pkg::CFG_W-1:0]    width_setting  = 12'd1;
    logic [tpe_pkg::CFG_W-1:0]    height_setting = 12'd1;
    bit                           sight_two_up [tpe_pkg::MAX_WIDTH];
    bit                           sight_one_up [tpe_pkg::MAX_WIDTH];
    logic [tpe_pkg::WINDOW_W-1:0] sight_window   = '0;
    int unsigned                  next_col       = 0;
    int unsigned                  next_row       = 0;

    verdict_t pending_verdicts [$];
    int       failures     = 0;
    int       cycle_count  = 0;
    bit       tx_busy      = 1'b1;
    bit       rx_busy      = 1'b1;
    bit       hold_request = 1'b0;

    always #CLK_HALF clk = ~clk;

    function automatic int unsigned clamp_dim(logic [tpe_pkg::CFG_W-1:0] v, int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    // Any decoded write restarts the map; the line buffers keep their contents.
    function automatic void set_register(logic [tpe_pkg::CFG_INDEX_W-1:0] idx,
                                         logic [tpe_pkg::CFG_W-1:0] val);
        if (idx == tpe_pkg::REG_MAP_WIDTH)
            width_setting = val;
        else if (idx == tpe_pkg::REG_MAP_HEIGHT)
            height_setting = val;
        else
            return;
        sight_window = '0;
        next_col     = 0;
        next_row     = 0;
    endfunction

    // Classify one tile, shift the sight window and advance the raster position.
    function automatic verdict_t classify_tile(tile_t t);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic        walk;
        logic        sight;
        verdict_t    v;
        w = clamp_dim(width_setting, tpe_pkg::MAX_WIDTH);
        h = clamp_dim(height_setting, tpe_pkg::HEIGHT_LIMIT);
        c = (next_col >= w) ? 0 : next_col;
        r = (next_row >= h) ? 0 : next_row;
        walk  = t.tile_walkable & ~(t.wall_present & ~t.wall_walkable)
              & ~(t.doodad_present & ~t.doodad_walkable);
        sight = t.tile_blocks_sight | (t.wall_present & t.wall_blocks_sight);
        sight_window = {sight_window[tpe_pkg::WINDOW_W-4:0],
                        sight_two_up[c], sight_one_up[c], sight};
        sight_two_up[c] = sight_one_up[c];
        sight_one_up[c] = sight;
        v = '0;
        v.walkable     = walk;
        v.blocks_sight = sight;
        // Only tiles with a full neighbourhood inside the map get a verdict.
        if (c >= 2 && r >= 2)
        begin
            v.obscured_valid = 1'b1;
            v.obscured       = &sight_window;
            v.obscured_col   = tpe_pkg::COORD_W'(c - 1);
            v.obscured_row   = tpe_pkg::COORD_W'(r - 1);
        end
        v.last_tile = (c == w - 1) && (r == h - 1);
        if (c + 1 >= w)
        begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
        return v;
    endfunction

    function automatic tile_t random_tile(int sight_pct);
        tile_t t;
        t = tile_t'(7'($urandom));
        t.tile_blocks_sight = ($urandom_range(0, 99) < sight_pct);
        return t;
    endfunction

    // Entered and left at a falling edge; the write lands at the rising edge between.
    task automatic write_register(logic [tpe_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [tpe_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        set_register(idx, val);
    endtask

    // Let every outstanding result drain before touching the registers.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    // Offer one tile, after a random gap when tx_busy is set, and record its expected result on transfer.
    task automatic send_tile(tile_t t, want_src_t src, verdict_t typed);
        int       gap;
        verdict_t predicted;
        verdict_t expected;
        gap = tx_busy ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.tile_walkable     <= t.tile_walkable;
        in_ch.tile_blocks_sight <= t.tile_blocks_sight;
        in_ch.wall_present      <= t.wall_present;
        in_ch.wall_walkable     <= t.wall_walkable;
        in_ch.wall_blocks_sight <= t.wall_blocks_sight;
        in_ch.doodad_present    <= t.doodad_present;
        in_ch.doodad_walkable   <= t.doodad_walkable;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = classify_tile(t);
        expected  = (src == WANT_TYPED) ? typed : predicted;
        pending_verdicts.insert(pending_verdicts.size(), expected);
        @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        int                        w_pick;
        int                        h_pick;
        int                        n_tiles;
        int                        map_tiles;
        int unsigned               w_eff;
        int unsigned               h_eff;
        int                        sight_pct;
        int                        random_sent;
        logic [tpe_pkg::CFG_W-1:0] w_val;
        logic [tpe_pkg::CFG_W-1:0] h_val;
        verdict_t                  typed;

        clk                     = 1'b0;
        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        in_ch.valid             = 1'b0;
        in_ch.tile_walkable     = 1'b0;
        in_ch.tile_blocks_sight = 1'b0;
        in_ch.wall_present      = 1'b0;
        in_ch.wall_walkable     = 1'b0;
        in_ch.wall_blocks_sight = 1'b0;
        in_ch.doodad_present    = 1'b0;
        in_ch.doodad_walkable   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            if (STEPS[i].kind == STEP_WRITE)
            begin
                wait_idle();
                write_register(STEPS[i].reg_index, STEPS[i].reg_value);
            end
            else
            begin
                typed              = '0;
                typed.walkable     = STEPS[i].want_walkable;
                typed.blocks_sight = STEPS[i].want_sight;
                typed.last_tile    = STEPS[i].want_last;
                send_tile(STEPS[i].tile, STEPS[i].want_src, typed);
            end
        end

        // Widest row: an oversize width acts as the full line buffer width
        wait_idle();
        write_register(tpe_pkg::REG_MAP_WIDTH, SIZE_TOP);
        write_register(tpe_pkg::REG_MAP_HEIGHT, 12'd1);
        tx_busy = 1'b0;
        repeat (WIDE_TILES) send_tile(random_tile(50), WANT_PREDICTED, '0);

        // Long receiver hold-off while tiles keep coming back to back
        wait_idle();
        write_register(tpe_pkg::REG_MAP_WIDTH, 12'd8);
        write_register(tpe_pkg::REG_MAP_HEIGHT, 12'd8);
        hold_request = 1'b1;
        repeat (128) send_tile(random_tile(90), WANT_PREDICTED, '0);

        // Random maps: mostly whole maps, some cut short by the next restart
        random_sent = 0;
        while (random_sent < RANDOM_TILES)
        begin
            wait_idle();
            tx_busy = ($urandom_range(0, 3) != 0);
            rx_busy = ($urandom_range(0, 3) != 0);
            w_pick  = $urandom_range(0, 19);
            h_pick  = $urandom_range(0, 19);
            case (w_pick)
                0:       w_val = 12'd0;
                1:       w_val = 12'd1;
                2:       w_val = 12'd2;
                3:       w_val = 12'($urandom_range(13, 64));
                4:       w_val = 12'(tpe_pkg::MAX_WIDTH);
                default: w_val = 12'($urandom_range(3, 12));
            endcase
            case (h_pick)
                0:       h_val = 12'd0;
                1:       h_val = 12'd1;
                2:       h_val = 12'd2;
                3:       h_val = SIZE_TOP;
                4:       h_val = 12'(tpe_pkg::HEIGHT_LIMIT);
                default: h_val = 12'($urandom_range(3, 8));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_register(tpe_pkg::REG_MAP_WIDTH, w_val);
                write_register(tpe_pkg::REG_MAP_HEIGHT, h_val);
            end
            else
            begin
                write_register(tpe_pkg::REG_MAP_HEIGHT, h_val);
                write_register(tpe_pkg::REG_MAP_WIDTH, w_val);
            end
            if ($urandom_range(0, 5) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 12'($urandom));
            case ($urandom_range(0, 2))
                0:       sight_pct = 50;
                1:       sight_pct = 85;
                default: sight_pct = 97;
            endcase
            w_eff     = clamp_dim(width_setting, tpe_pkg::MAX_WIDTH);
            h_eff     = clamp_dim(height_setting, tpe_pkg::HEIGHT_LIMIT);
            map_tiles = w_eff * h_eff;
            if (map_tiles <= 160)
                n_tiles = ($urandom_range(0, 3) == 0) ? $urandom_range(1, map_tiles)
                                                      : map_tiles * $urandom_range(1, 2);
            else if (w_eff > 64)
                n_tiles = $urandom_range(16, w_eff / 4);
            else
                n_tiles = $urandom_range(2 * w_eff, 4 * w_eff);
            repeat (n_tiles) send_tile(random_tile(sight_pct), WANT_PREDICTED, '0);
            random_sent += n_tiles;
        end

        // Drain and report
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending_verdicts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when asked for
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
            begin
                gap = rx_busy ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t seen;
        verdict_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.walkable       = out_ch.walkable;
            seen.blocks_sight   = out_ch.blocks_sight;
            seen.obscured_valid = out_ch.obscured_valid;
            seen.obscured       = out_ch.obscured;
            seen.obscured_col   = out_ch.obscured_col;
            seen.obscured_row   = out_ch.obscured_row;
            seen.last_tile      = out_ch.last_tile;
            if (pending_verdicts.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("cycle %0d: result transfer with none expected: %p",
                             cycle_count, seen);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (seen !== want)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display({"cycle %0d: expected/actual walkable %b/%b sight %b/%b ",
                                  "verdict %b/%b obscured %b/%b col %0d/%0d row %0d/%0d ",
                                  "last %b/%b"},
                                 cycle_count, want.walkable, seen.walkable,
                                 want.blocks_sight, seen.blocks_sight,
                                 want.obscured_valid, seen.obscured_valid,
                                 want.obscured, seen.obscured,
                                 want.obscured_col, seen.obscured_col,
                                 want.obscured_row, seen.obscured_row,
                                 want.last_tile, seen.last_tile);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

FILE: filelist.f
src/tpe_pkg.sv
src/tpe_in_if.sv
src/tpe_out_if.sv
src/tpe_ram.sv
src/tpe_front.sv
src/tpe_queue.sv
src/tpe_back.sv
src/tile_passability_and_erosion.sv
tb/sv/tb_top.sv
